// ===== rtl/core/fctc_pkg.sv =====
// Package: shared payload types, command and status structs for the Fock contraction core
package fctc_pkg;

  // Operation codes of an input transaction
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_INTEGRAL = 1'b1;

  // Width of the basis count register and of the row and column tags
  localparam int unsigned BasisW = 7;
  localparam int unsigned TagW   = 6;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] density_value;
    logic signed [31:0] coulomb_value;
    logic signed [31:0] exchange_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] fock_value;
    logic [TagW-1:0]    row;
    logic [TagW-1:0]    col;
    logic               last_pair;
  } out_item_t;

  typedef struct packed {
    logic [BasisW-1:0] basis_count;
  } cfg_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // write density element, advance load index
    logic capture;  // latch integrals, read density store
    logic mult;     // register both products
    logic accum;    // add products, advance element index
    logic diff;     // form coulomb minus half exchange
    logic emit;     // load output register, restart the pair
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic elem_last;  // accumulated element is the pair's final one
  } dp_status_t;

endpackage

// ===== rtl/core/fctc_chan_if.sv =====
// Interface: valid/ready channel carrying one payload struct
interface fctc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/fctc_ctrl.sv =====
// Module: sequencing state machine for loads, multiply-accumulate and result emission
module fctc_ctrl import fctc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_operation_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_ACCUM,
    ST_DIFF,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_fire;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // Decode commands from the current state and the input handshake
  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = in_fire && (in_operation_i == OP_LOAD);
    cmd_o.capture = in_fire && (in_operation_i == OP_INTEGRAL);
    cmd_o.mult    = (state_q == ST_MULT);
    cmd_o.accum   = (state_q == ST_ACCUM);
    cmd_o.diff    = (state_q == ST_DIFF);
    cmd_o.emit    = (state_q == ST_EMIT) && out_free;
  end

  // Hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.capture) begin
            state_q <= ST_MULT;
          end
        end
        ST_MULT: begin
          state_q <= ST_ACCUM;
        end
        ST_ACCUM: begin
          state_q <= status_i.elem_last ? ST_DIFF : ST_IDLE;
        end
        ST_DIFF: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/fctc_datapath.sv =====
// Module: density store, multipliers, accumulators, counters and saturation
module fctc_datapath import fctc_pkg::*; #(
  parameter int unsigned MAX_BASIS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  input  in_item_t   in_item_i,
  input  logic       cfg_we_i,
  input  cfg_item_t  cfg_item_i,
  output out_item_t  out_item_o
);

  localparam int unsigned Depth = MAX_BASIS * MAX_BASIS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NW    = $clog2(MAX_BASIS + 1);
  localparam int unsigned TW    = $clog2(Depth + 1);

  // Density store, undefined until loaded
  logic [31:0] density_store_q [Depth];

  logic [NW-1:0] n_q, n_d;
  logic [TW-1:0] total_q, total_d;
  logic [TW-1:0] load_idx_q, load_next;
  logic [TW-1:0] elem_idx_q;
  logic [NW-1:0] row_q, col_q, row_d, col_d, row_inc, col_inc;
  logic [63:0]   acc_c_q, acc_x_q;
  logic [8:0]    basis_ext;

  logic signed [31:0] rd_q, cv_q, ev_q;
  logic signed [63:0] prod_c_q, prod_x_q;
  logic [63:0]        half_x;
  logic [64:0]        diff_q;
  logic [48:0]        scaled;
  logic               ovf;
  logic [31:0]        fock_sat;
  out_item_t          out_q;

  // Clamp the basis count to 1..MAX_BASIS and square it
  assign basis_ext = {2'b00, cfg_item_i.basis_count};
  always_comb begin
    if (basis_ext == 9'd0) begin
      n_d = NW'(1);
    end else if (32'(basis_ext) > MAX_BASIS) begin
      n_d = NW'(MAX_BASIS);
    end else begin
      n_d = NW'(basis_ext);
    end
    total_d = TW'(TW'(n_d) * TW'(n_d));
  end

  assign load_next          = load_idx_q + TW'(1);
  assign status_o.elem_last = (elem_idx_q == total_q - TW'(1));

  // Step to the next lower-triangle pair, column-major, wrapping at the end
  assign row_inc = row_q + NW'(1);
  assign col_inc = col_q + NW'(1);
  always_comb begin
    row_d = row_inc;
    col_d = col_q;
    if (row_inc >= n_q) begin
      if (col_inc >= n_q) begin
        row_d = '0;
        col_d = '0;
      end else begin
        row_d = col_inc;
        col_d = col_inc;
      end
    end
  end

  // Control counters and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q        <= NW'(1);
      total_q    <= TW'(1);
      load_idx_q <= '0;
      elem_idx_q <= '0;
      acc_c_q    <= '0;
      acc_x_q    <= '0;
      row_q      <= '0;
      col_q      <= '0;
    end else if (cfg_we_i) begin
      n_q        <= n_d;
      total_q    <= total_d;
      load_idx_q <= '0;
      elem_idx_q <= '0;
      acc_c_q    <= '0;
      acc_x_q    <= '0;
      row_q      <= '0;
      col_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        load_idx_q <= (load_next == total_q) ? '0 : load_next;
      end
      if (cmd_i.accum) begin
        acc_c_q    <= acc_c_q + prod_c_q;
        acc_x_q    <= acc_x_q + prod_x_q;
        elem_idx_q <= elem_idx_q + TW'(1);
      end
      if (cmd_i.emit) begin
        acc_c_q    <= '0;
        acc_x_q    <= '0;
        elem_idx_q <= '0;
        row_q      <= row_d;
        col_q      <= col_d;
      end
    end
  end

  // Write and read the density store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      density_store_q[load_idx_q[AW-1:0]] <= in_item_i.density_value;
    end
    if (cmd_i.capture) begin
      rd_q <= density_store_q[elem_idx_q[AW-1:0]];
    end
  end

  // Latch integrals, multiply, subtract
  assign half_x = {acc_x_q[63], acc_x_q[63:1]};
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cv_q <= in_item_i.coulomb_value;
      ev_q <= in_item_i.exchange_value;
    end
    if (cmd_i.mult) begin
      prod_c_q <= cv_q * rd_q;
      prod_x_q <= ev_q * rd_q;
    end
    if (cmd_i.diff) begin
      diff_q <= {acc_c_q[63], acc_c_q} - {half_x[63], half_x};
    end
  end

  // Scale back to Q16.16 and saturate
  assign scaled   = diff_q[64:16];
  assign ovf      = !((&scaled[48:31]) || !(|scaled[48:31]));
  assign fock_sat = ovf ? (scaled[48] ? 32'h8000_0000 : 32'h7FFF_FFFF) : scaled[31:0];

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.fock_value <= fock_sat;
      out_q.row        <= TagW'(row_q);
      out_q.col        <= TagW'(col_q);
      out_q.last_pair  <= (col_q == n_q - NW'(1));
    end
  end

  assign out_item_o = out_q;

endmodule

// ===== rtl/core/fock_two_electron_contraction_core.sv =====
// Top level: Fock two-electron contraction core, controller plus datapath
//
//  channel | direction | payload                                          | accepted when
//  in_i    | sink      | operation, density/coulomb/exchange Q16.16       | valid && ready
//  out_o   | source    | fock_value, row, col, last_pair                  | valid && ready
//  cfg_i   | sink      | basis_count (7 bits)                             | valid && ready
//
// A load transaction is taken in idle; an integral transaction passes the store read,
// multiply and accumulate steps, and the last element of a pair also subtract and emit
// (saturate into the output register), where an output stall holds it. Reset clears
// counters, accumulators and sets basis_count to 1; the density store is undefined until
// loaded. A result waits in the output register while new items are taken; the core
// stalls only when a second result is ready before the first is taken. Config writes
// are always ready.
module fock_two_electron_contraction_core import fctc_pkg::*; #(
  parameter int unsigned MAX_BASIS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fctc_chan_if.sink   in_i,
  fctc_chan_if.source out_o,
  fctc_chan_if.sink   cfg_i
);

  dp_cmd_t    cmd;
  dp_status_t status;
  in_item_t   in_item;
  cfg_item_t  cfg_item;
  out_item_t  out_item;

  assign in_item       = in_i.payload;
  assign cfg_item      = cfg_i.payload;
  assign cfg_i.ready   = 1'b1;
  assign out_o.payload = out_item;

  fctc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_operation_i (in_item.operation),
    .in_ready_o     (in_i.ready),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  fctc_datapath #(
    .MAX_BASIS (MAX_BASIS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_item_i  (in_item),
    .cfg_we_i   (cfg_i.valid),
    .cfg_item_i (cfg_item),
    .out_item_o (out_item)
  );

endmodule

// ===== rtl/core/fctc_checker.sv =====
// Checker: port-level assertions for the Fock contraction core, with its bind
module fctc_checker import fctc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input in_item_t  in_item_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_item_i
);

  // A pending result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transaction");

  // An integral transaction keeps the core busy the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_item_i.operation == OP_INTEGRAL) |=> !in_ready_i)
    else $error("input taken during multiply-accumulate");

  // A new result only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without accumulation");

  // The final pair sits on the diagonal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.last_pair |-> (out_item_i.row == out_item_i.col))
    else $error("last pair off the diagonal");

endmodule

bind fock_two_electron_contraction_core fctc_checker u_fctc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_item_i   (in_item),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_item)
);

// ===== sim/testbench.sv =====
// Testbench for the Fock two-electron contraction core: random and directed streams, self-checking
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fctc_pkg::*;

  localparam int unsigned MAX_BASIS        = 64;
  localparam int unsigned STORE_WORDS      = MAX_BASIS * MAX_BASIS;
  localparam int          IDLE_PCT         = 16;
  localparam int          LOAD_PCT         = 15;
  localparam int          SINK_HOLD_CYCLES = 300;
  localparam int          SETTLE_CYCLES    = 12;
  localparam int          WATCHDOG_LIMIT   = 2000;

  localparam logic signed [31:0] Q16_MIN = 32'sh80000000;
  localparam logic signed [31:0] Q16_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q16_ONE = 32'sh00010000;

  // Predicts each pair's Fock element and checks results in order
  class fock_checker;
    bit [31:0]       density_mem [STORE_WORDS];
    int unsigned     load_idx;
    int unsigned     elem_idx;
    int unsigned     row_cnt;
    int unsigned     col_cnt;
    bit [63:0]       coul_acc;
    bit [63:0]       exch_acc;
    bit [BasisW-1:0] basis;
    out_item_t       fock_q [$];
    int              errors;

    function new();
      basis  = 1;
      errors = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      load_idx = 0;
      elem_idx = 0;
      row_cnt  = 0;
      col_cnt  = 0;
      coul_acc = '0;
      exch_acc = '0;
    endfunction

    function void set_basis(bit [BasisW-1:0] value);
      basis = value;
      clear_stream();
    endfunction

    function int unsigned basis_eff();
      if (basis == 0) return 1;
      if (basis > MAX_BASIS) return MAX_BASIS;
      return basis;
    endfunction

    // Coulomb minus half exchange, floor-scaled to Q16.16 and saturated
    function logic signed [31:0] pair_fock();
      logic signed [63:0] half;
      logic signed [64:0] diff;
      logic signed [64:0] scaled;
      half   = $signed(exch_acc) >>> 1;
      diff   = $signed({coul_acc[63], coul_acc}) - $signed({half[63], half});
      scaled = diff >>> 16;
      if (scaled > 65'sd2147483647) return Q16_MAX;
      if (scaled < -65'sd2147483648) return Q16_MIN;
      return scaled[31:0];
    endfunction

    function void note_accepted(in_item_t it);
      int unsigned        n;
      int unsigned        total;
      logic signed [63:0] dens;
      logic signed [63:0] coul;
      logic signed [63:0] exch;
      out_item_t          want;
      n     = basis_eff();
      total = n * n;
      // Store density element, wrap after n*n loads
      if (it.operation == OP_LOAD) begin
        if (load_idx >= total) load_idx = 0;
        density_mem[load_idx] = it.density_value;
        load_idx++;
        if (load_idx >= total) load_idx = 0;
        return;
      end
      // Accumulate both products against the running density element
      if (elem_idx >= total) elem_idx = total - 1;
      dens = $signed(density_mem[elem_idx]);
      coul = $signed(it.coulomb_value);
      exch = $signed(it.exchange_value);
      coul_acc += coul * dens;
      exch_acc += exch * dens;
      elem_idx++;
      if (elem_idx < total) return;
      // Pair complete: queue the element, advance through the lower triangle
      want.fock_value = pair_fock();
      want.row        = row_cnt[TagW-1:0];
      want.col        = col_cnt[TagW-1:0];
      want.last_pair  = (col_cnt >= n - 1);
      fock_q.push_back(want);
      elem_idx = 0;
      coul_acc = '0;
      exch_acc = '0;
      row_cnt++;
      if (row_cnt >= n) begin
        col_cnt++;
        row_cnt = col_cnt;
        if (col_cnt >= n) begin
          col_cnt = 0;
          row_cnt = 0;
        end
      end
    endfunction

    function void check_fock(out_item_t got);
      out_item_t want;
      if (fock_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value %h row %0d col %0d last %0b",
                 $time, got.fock_value, got.row, got.col, got.last_pair);
      end else begin
        want = fock_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected value %h row %0d col %0d last %0b, actual value %h row %0d col %0d last %0b",
                   $time, want.fock_value, want.row, want.col, want.last_pair,
                   got.fock_value, got.row, got.col, got.last_pair);
        end
      end
    endfunction

    function int pending();
      return fock_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int          idle_pct = IDLE_PCT;
  bit          sink_hold_req = 1'b0;
  int          quiet_cycles = 0;
  fock_checker fock_track = new();

  fctc_chan_if #(.payload_t(in_item_t))  in_if ();
  fctc_chan_if #(.payload_t(out_item_t)) out_if ();
  fctc_chan_if #(.payload_t(cfg_item_t)) cfg_if ();

  fock_two_electron_contraction_core #(
    .MAX_BASIS(MAX_BASIS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Draw a Q16.16 value: narrow keeps sums in range, wide mixes full range and extremes
  function automatic logic signed [31:0] q16_value(bit wide);
    int unsigned roll;
    if (!wide) return $signed($urandom_range(0, 262143)) - 131072;
    roll = $urandom_range(0, 9);
    if (roll < 4) return $signed($urandom_range(0, 262143)) - 131072;
    if (roll < 8) return $urandom();
    case ($urandom_range(0, 4))
      0:       return Q16_MIN;
      1:       return Q16_MAX;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return Q16_ONE;
    endcase
  endfunction

  // Offer one transaction from a falling edge, return at the falling edge after acceptance
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    fock_track.note_accepted(it);
    @(negedge clk_i);
  endtask

  task automatic send_load(logic signed [31:0] dens);
    in_item_t it;
    it.operation      = OP_LOAD;
    it.density_value  = dens;
    it.coulomb_value  = $urandom();
    it.exchange_value = $urandom();
    send_item(it);
  endtask

  task automatic send_integral(logic signed [31:0] coul, logic signed [31:0] exch);
    in_item_t it;
    it.operation      = OP_INTEGRAL;
    it.density_value  = $urandom();
    it.coulomb_value  = coul;
    it.exchange_value = exch;
    send_item(it);
  endtask

  // Drop valid, wait for every pending result, then let the pipeline empty
  task automatic settle();
    in_if.valid <= 1'b0;
    while (fock_track.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_basis(bit [BasisW-1:0] value);
    cfg_item_t w;
    w.basis_count  = value;
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    fock_track.set_basis(value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Set n, fill as much of the store as the stream can read, then stream integrals
  // with loads mixed in
  task automatic run_phase(bit [BasisW-1:0] basis_val, int unsigned items, bit dense_wide,
                           bit with_hold);
    int unsigned n;
    int unsigned nn;
    int unsigned preload;
    int unsigned integrals;
    bit          pair_wide;
    settle();
    write_basis(basis_val);
    n         = (basis_val == 0) ? 1 : ((basis_val > MAX_BASIS) ? MAX_BASIS : basis_val);
    nn        = n * n;
    preload   = (nn < items) ? nn : items;
    integrals = 0;
    pair_wide = 1'b0;
    repeat (preload) send_load(q16_value(dense_wide));
    for (int unsigned k = 0; k < items; k++) begin
      if (with_hold && k == 20) sink_hold_req = 1'b1;
      if ($urandom_range(0, 99) < LOAD_PCT) begin
        send_load(q16_value(dense_wide));
      end else begin
        if (integrals % nn == 0) pair_wide = 1'($urandom_range(0, 1));
        send_integral(q16_value(pair_wide), q16_value(pair_wide));
        integrals++;
      end
    end
  endtask

  // Result side: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        hold_left     = SINK_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) fock_track.check_fock(out_if.payload);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset size of one: saturation both ways, floor of the half, load overwrite
    send_load(Q16_MIN);
    send_integral(Q16_MIN, Q16_MIN);
    send_integral(Q16_MAX, Q16_MIN);
    send_load(Q16_ONE);
    send_integral(32'sh00030000, 32'sh00020000);
    send_integral(32'sd0, -32'sd1);
    send_integral(32'sd0, 32'sd1);

    // Zero register acts as one
    settle();
    write_basis(0);
    send_load(32'shFFFF0000);
    send_integral(32'sh00008000, Q16_MAX);

    // Size two: overflow of the difference, wrap of the accumulator, full build
    settle();
    write_basis(2);
    repeat (4) send_load(Q16_MIN);
    send_integral(Q16_MIN, Q16_MAX);
    send_integral(Q16_MAX, Q16_MAX);
    send_integral(32'sd0, 32'sd0);
    send_integral(32'sd0, 32'sd0);
    repeat (4) send_integral(Q16_MIN, 32'sd0);
    repeat (4) send_integral(32'sh00020000, 32'shFFFE0000);

    // Random phases over several sizes; the first size-one phase stalls the sink for a long stretch
    run_phase(3, 170, 1'b1, 1'b0);
    run_phase(1, 110, 1'b0, 1'b1);
    idle_pct = 0;
    run_phase(4, 210, 1'b0, 1'b0);
    idle_pct = IDLE_PCT;
    run_phase(5, 300, 1'b0, 1'b0);
    run_phase(2, 120, 1'b1, 1'b0);
    run_phase(3, 150, 1'b0, 1'b0);
    run_phase(1, 80, 1'b1, 1'b0);
    run_phase(MAX_BASIS, 100, 1'b0, 1'b0);
    run_phase(127, 60, 1'b0, 1'b0);
    run_phase(1, 40, 1'b1, 1'b0);
    settle();

    if (fock_track.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
